// ===== rtl/core/jmse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG metadata extractor package
// Shared item types, controller/datapath interface types, marker codes and
// signature tables.
// ----------------------------------------------------------------------------
package jmse_pkg;

  localparam int PREFIX_DEPTH_DEF = 29;

  localparam int LEN_SIG_EXIF = 5;
  localparam int LEN_SIG_XMP  = 29;
  localparam int LEN_ICC_HDR  = 14;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_APP1   = 8'hE1;
  localparam logic [7:0] MARK_APP2   = 8'hE2;
  localparam logic [7:0] MARK_IPTC   = 8'hED;
  localparam logic [7:0] MARK_COM    = 8'hFE;
  localparam logic [3:0] MARK_APPN_HI = 4'hE;

  localparam logic [3:0] CAP_ALL = 4'hF;

  // "Exif" NUL
  localparam logic [8*LEN_SIG_EXIF-1:0] SIG_EXIF = 40'h45_78_69_66_00;
  // XMP namespace URI with its NUL
  localparam logic [8*LEN_SIG_XMP-1:0] SIG_XMP =
    232'h68_74_74_70_3A_2F_2F_6E_73_2E_61_64_6F_62_65_2E_63_6F_6D_2F_78_61_70_2F_31_2E_30_2F_00;
  // ICC segment tag string, NUL, then 0x01 0x01
  localparam logic [8*LEN_ICC_HDR-1:0] ICC_HDR = 112'h49_43_43_5F_50_52_4F_46_49_4C_45_00_01_01;

  typedef enum logic [2:0] {
    KIND_EXIF = 3'd0,
    KIND_XMP  = 3'd1,
    KIND_ICC  = 3'd2,
    KIND_IPTC = 3'd3,
    KIND_END  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    kind_t      kind;
    logic       last_of_segment;
    logic       icc_header_ok;
  } out_item_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_MARK,
    DP_LEN_HI,
    DP_LEN_LO,
    DP_COUNT,
    DP_APP1,
    DP_ICC
  } dp_op_t;

  typedef struct packed {
    logic       clear;
    dp_op_t     op;
    logic       burst_start;
    logic       burst_go;
    logic [3:0] cap_set;
    logic       out_load;
    logic       out_zero;
    kind_t      out_kind;
    logic       out_last;
    logic       out_ok;
  } cmd_t;

  typedef struct packed {
    logic       out_ok;
    logic       byte_ff;
    logic       byte_seg;
    logic       len_zero;
    logic       len_short;
    logic       len_icc;
    logic       mk_app1;
    logic       mk_app2;
    logic       mk_iptc;
    logic       rem_last;
    logic       rem_zero;
    logic       total_short;
    logic       at_exif;
    logic       at_xmp;
    logic       exif_hit;
    logic       xmp_hit;
    logic       icc_ok;
    logic [3:0] cap;
    logic       burst_done;
  } st_t;

  function automatic logic [7:0] sig_exif_byte(input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (int'(idx) < LEN_SIG_EXIF) begin
      b = SIG_EXIF[8*(LEN_SIG_EXIF-1-int'(idx)) +: 8];
    end
    return b;
  endfunction

  function automatic logic [7:0] sig_xmp_byte(input logic [4:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (int'(idx) < LEN_SIG_XMP) begin
      b = SIG_XMP[8*(LEN_SIG_XMP-1-int'(idx)) +: 8];
    end
    return b;
  endfunction

  function automatic logic [7:0] icc_hdr_byte(input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (int'(idx) < LEN_ICC_HDR) begin
      b = ICC_HDR[8*(LEN_ICC_HDR-1-int'(idx)) +: 8];
    end
    return b;
  endfunction

  function automatic logic [3:0] kind_bit(input kind_t k);
    logic [3:0] m;
    unique case (k)
      KIND_EXIF: m = 4'b0001;
      KIND_XMP:  m = 4'b0010;
      KIND_ICC:  m = 4'b0100;
      KIND_IPTC: m = 4'b1000;
      default:   m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/jpeg_metadata_segment_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG metadata segment extractor
// Walks JPEG marker segments byte by byte and streams out the payloads of the
// first Exif APP1, XMP APP1, valid ICC APP2 and IPTC segments, then an end
// item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in_     | into      | in_valid / in_stall  | data_byte, new_image
//  out_    | out of    | out_valid / out_stall| payload_byte, kind, last, icc ok
//
// Cycles: one cycle per input byte while the output register can take one.
// An APP1 whose signature decides at the fifth or twenty-ninth byte
// releases the held prefix (5 or 29 items) from the registered prefix RAM,
// one byte per cycle while out_stall is low, with input held off meanwhile.
// A segment's last byte that completes the capture set leads to the end item.
// Reset: synchronous, active low; the prefix RAM needs no clearing pass.
// Stalls: out_stall holds the output register, and input is held off until
// the register can take a new item.
//
// The controller owns the parse phase; the datapath owns length, flags,
// signature compare, prefix store and the output register.

module jpeg_metadata_segment_extractor #(
  parameter int PREFIX_DEPTH = jmse_pkg::PREFIX_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jmse_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output jmse_pkg::out_item_t out_item
);

  jmse_pkg::cmd_t cmd;
  jmse_pkg::st_t  st;

  // Sequence the parse and the prefix bursts
  jmse_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_new_image (in_item.new_image),
    .in_stall     (in_stall),
    .st           (st),
    .cmd          (cmd)
  );

  // Hold segment state, prefix RAM and the result register
  jmse_dp #(
    .PREFIX_DEPTH (PREFIX_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_item.data_byte),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/jmse_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module jmse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/jmse_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG metadata extractor datapath
// Segment length, capture flags, signature match tracking, APP1 prefix store
// with burst readout, and the output register.
// ----------------------------------------------------------------------------
module jmse_dp #(
  parameter int PREFIX_DEPTH = jmse_pkg::PREFIX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_data,
  input  logic               out_stall,
  input  jmse_pkg::cmd_t     cmd,
  output jmse_pkg::st_t      st,
  output logic               out_valid,
  output jmse_pkg::out_item_t out_item
);

  localparam int CW = $clog2(PREFIX_DEPTH + 1);
  localparam int AW = $clog2(PREFIX_DEPTH);

  logic [15:0]   rem_r, rem_nxt;
  logic [7:0]    mark_r, mark_nxt;
  logic [3:0]    cap_r, cap_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    pidx_r, pidx_nxt;
  logic          icc_match_r, icc_match_nxt;
  logic          exif_match_r, exif_match_nxt;
  logic          xmp_match_r, xmp_match_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  jmse_pkg::out_item_t out_item_r, out_item_nxt;

  logic          out_ok;
  logic [15:0]   len_full, len_adj, rem_dec;
  logic [CW-1:0] cnt_inc;
  logic          exif_hit, xmp_hit, icc_hit, pidx_lt, icc_ok;
  logic [3:0]    pidx_inc;
  logic          has_more, ld, issue;
  logic [7:0]    rdata;

  assign out_ok   = !out_valid_r || !out_stall;
  assign len_full = {rem_r[15:8], in_data};
  assign len_adj  = (len_full > 16'd2) ? (len_full - 16'd2) : len_full;
  assign rem_dec  = (rem_r != 16'd0) ? (rem_r - 16'd1) : 16'd0;
  assign cnt_inc  = cnt_r + CW'(1);

  // Running signature compare, one byte per accepted item
  assign exif_hit = exif_match_r && ((cnt_r >= CW'(jmse_pkg::LEN_SIG_EXIF)) ||
                    (in_data == jmse_pkg::sig_exif_byte(cnt_r[2:0])));
  assign xmp_hit  = xmp_match_r && ((cnt_r >= CW'(jmse_pkg::LEN_SIG_XMP)) ||
                    (in_data == jmse_pkg::sig_xmp_byte(cnt_r[4:0])));

  assign pidx_lt  = pidx_r < 4'(jmse_pkg::LEN_ICC_HDR);
  assign icc_hit  = icc_match_r && (!pidx_lt || (in_data == jmse_pkg::icc_hdr_byte(pidx_r)));
  assign pidx_inc = pidx_lt ? (pidx_r + 4'd1) : pidx_r;
  assign icc_ok   = icc_hit && (pidx_inc >= 4'(jmse_pkg::LEN_ICC_HDR));

  // Burst readout: one read in flight, refill as the output register drains
  assign has_more = rd_idx_r < cnt_r;
  assign ld       = cmd.burst_go && rd_pend_r && out_ok;
  assign issue    = cmd.burst_go && has_more && (!rd_pend_r || ld);

  jmse_ram #(
    .WIDTH (8),
    .DEPTH (PREFIX_DEPTH)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (cmd.op == jmse_pkg::DP_APP1),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_data),
    .re    (issue),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    rem_nxt        = rem_r;
    mark_nxt       = mark_r;
    cap_nxt        = cap_r | cmd.cap_set;
    cnt_nxt        = cnt_r;
    pidx_nxt       = pidx_r;
    icc_match_nxt  = icc_match_r;
    exif_match_nxt = exif_match_r;
    xmp_match_nxt  = xmp_match_r;
    if (cmd.clear) begin
      rem_nxt        = '0;
      mark_nxt       = '0;
      cap_nxt        = '0;
      cnt_nxt        = '0;
      pidx_nxt       = '0;
      icc_match_nxt  = 1'b1;
      exif_match_nxt = 1'b1;
      xmp_match_nxt  = 1'b1;
    end else begin
      unique case (cmd.op)
        jmse_pkg::DP_MARK: begin
          if (st.byte_seg) begin
            mark_nxt = in_data;
            rem_nxt  = '0;
          end
        end
        jmse_pkg::DP_LEN_HI: rem_nxt = {in_data, 8'h00};
        jmse_pkg::DP_LEN_LO: begin
          rem_nxt        = len_adj;
          mark_nxt       = '0;
          cnt_nxt        = '0;
          exif_match_nxt = 1'b1;
          xmp_match_nxt  = 1'b1;
          pidx_nxt       = '0;
          icc_match_nxt  = 1'b1;
        end
        jmse_pkg::DP_COUNT: rem_nxt = rem_dec;
        jmse_pkg::DP_APP1: begin
          rem_nxt        = rem_dec;
          cnt_nxt        = cnt_inc;
          exif_match_nxt = exif_hit;
          xmp_match_nxt  = xmp_hit;
        end
        jmse_pkg::DP_ICC: begin
          rem_nxt       = rem_dec;
          pidx_nxt      = pidx_inc;
          icc_match_nxt = icc_hit;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_idx_nxt  = rd_idx_r;
    rd_pend_nxt = rd_pend_r;
    if (cmd.burst_start) begin
      rd_idx_nxt  = '0;
      rd_pend_nxt = 1'b0;
    end else if (issue) begin
      rd_idx_nxt  = rd_idx_r + CW'(1);
      rd_pend_nxt = 1'b1;
    end else if (ld) begin
      rd_pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (ld) begin
      out_item_nxt.payload_byte    = rdata;
      out_item_nxt.kind            = cmd.out_kind;
      out_item_nxt.last_of_segment = !has_more && (rem_r == 16'd0);
      out_item_nxt.icc_header_ok   = 1'b0;
      out_valid_nxt                = 1'b1;
    end else if (cmd.out_load) begin
      out_item_nxt.payload_byte    = cmd.out_zero ? 8'h00 : in_data;
      out_item_nxt.kind            = cmd.out_kind;
      out_item_nxt.last_of_segment = cmd.out_last;
      out_item_nxt.icc_header_ok   = cmd.out_ok;
      out_valid_nxt                = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r        <= '0;
      mark_r       <= '0;
      cap_r        <= '0;
      cnt_r        <= '0;
      pidx_r       <= '0;
      icc_match_r  <= 1'b1;
      exif_match_r <= 1'b1;
      xmp_match_r  <= 1'b1;
      rd_idx_r     <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rem_r        <= rem_nxt;
      mark_r       <= mark_nxt;
      cap_r        <= cap_nxt;
      cnt_r        <= cnt_nxt;
      pidx_r       <= pidx_nxt;
      icc_match_r  <= icc_match_nxt;
      exif_match_r <= exif_match_nxt;
      xmp_match_r  <= xmp_match_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    st.out_ok      = out_ok;
    st.byte_ff     = in_data == jmse_pkg::MARK_PREFIX;
    st.byte_seg    = (in_data[7:4] == jmse_pkg::MARK_APPN_HI) || (in_data == jmse_pkg::MARK_COM);
    st.len_zero    = len_adj == 16'd0;
    st.len_short   = len_adj < 16'(jmse_pkg::LEN_SIG_EXIF);
    st.len_icc     = len_adj > 16'(jmse_pkg::LEN_ICC_HDR);
    st.mk_app1     = mark_r == jmse_pkg::MARK_APP1;
    st.mk_app2     = mark_r == jmse_pkg::MARK_APP2;
    st.mk_iptc     = mark_r == jmse_pkg::MARK_IPTC;
    st.rem_last    = rem_r <= 16'd1;
    st.rem_zero    = rem_r == 16'd0;
    st.total_short = rem_r < 16'(jmse_pkg::LEN_SIG_XMP - jmse_pkg::LEN_SIG_EXIF + 1);
    st.at_exif     = cnt_inc == CW'(jmse_pkg::LEN_SIG_EXIF);
    st.at_xmp      = cnt_inc >= CW'(jmse_pkg::LEN_SIG_XMP);
    st.exif_hit    = exif_hit;
    st.xmp_hit     = xmp_hit;
    st.icc_ok      = icc_ok;
    st.cap         = cap_r;
    st.burst_done  = ld && !has_more;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/jmse_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG metadata extractor controller
// Marker/segment parse state machine; issues datapath commands per item.
// ----------------------------------------------------------------------------
module jmse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_new_image,
  output logic           in_stall,
  input  jmse_pkg::st_t  st,
  output jmse_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    PH_MARK_START,
    PH_MARK_CODE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_APP1,
    PH_EXIF,
    PH_XMP,
    PH_ICC,
    PH_IPTC,
    PH_DONE,
    PH_BURST,
    PH_END_PEND
  } phase_t;

  phase_t          state_r, state_nxt, eff;
  jmse_pkg::kind_t burst_kind_r, burst_kind_nxt;
  logic            parse_st, accept;
  phase_t          skip_next, seg_next;

  assign parse_st = (state_r != PH_BURST) && (state_r != PH_END_PEND);
  assign in_stall = !(parse_st && st.out_ok);
  assign accept   = in_valid && !in_stall;
  assign eff      = in_new_image ? PH_MARK_START : state_r;

  always_comb begin
    cmd            = '0;
    cmd.op         = jmse_pkg::DP_IDLE;
    cmd.out_kind   = jmse_pkg::KIND_END;
    state_nxt      = state_r;
    burst_kind_nxt = burst_kind_r;
    skip_next      = st.rem_last ? PH_MARK_START : PH_SKIP;
    seg_next       = PH_MARK_START;

    unique case (state_r)
      PH_BURST: begin
        cmd.burst_go = 1'b1;
        cmd.out_kind = burst_kind_r;
        if (st.burst_done) begin
          if (st.rem_zero) begin
            cmd.cap_set = jmse_pkg::kind_bit(burst_kind_r);
            state_nxt   = ((st.cap | cmd.cap_set) == jmse_pkg::CAP_ALL) ? PH_END_PEND
                                                                        : PH_MARK_START;
          end else begin
            state_nxt = (burst_kind_r == jmse_pkg::KIND_EXIF) ? PH_EXIF : PH_XMP;
          end
        end
      end
      PH_END_PEND: begin
        if (st.out_ok) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = PH_DONE;
        end
      end
      default: begin
        if (accept) begin
          cmd.clear = in_new_image;
          priority case (eff)
            PH_MARK_START: begin
              if (st.byte_ff) begin
                state_nxt = PH_MARK_CODE;
              end else begin
                cmd.out_load = 1'b1;
                cmd.out_zero = 1'b1;
                cmd.out_last = 1'b1;
                state_nxt    = PH_DONE;
              end
            end
            PH_MARK_CODE: begin
              cmd.op    = jmse_pkg::DP_MARK;
              state_nxt = st.byte_seg ? PH_LEN_HI : PH_MARK_START;
            end
            PH_LEN_HI: begin
              cmd.op    = jmse_pkg::DP_LEN_HI;
              state_nxt = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              cmd.op = jmse_pkg::DP_LEN_LO;
              priority if (st.len_zero) begin
                state_nxt = PH_MARK_START;
              end else if (st.mk_app1 && (st.cap[1:0] != 2'b11)) begin
                state_nxt = st.len_short ? PH_SKIP : PH_APP1;
              end else if (st.mk_app2 && !st.cap[2] && st.len_icc) begin
                state_nxt = PH_ICC;
              end else if (st.mk_iptc && !st.cap[3]) begin
                state_nxt = PH_IPTC;
              end else begin
                state_nxt = PH_SKIP;
              end
            end
            PH_SKIP: begin
              cmd.op = jmse_pkg::DP_COUNT;
              if (st.rem_last) begin
                state_nxt = PH_MARK_START;
              end
            end
            PH_APP1: begin
              cmd.op = jmse_pkg::DP_APP1;
              priority if (st.at_exif) begin
                priority if (st.exif_hit) begin
                  if (st.cap[0]) begin
                    state_nxt = skip_next;
                  end else begin
                    cmd.burst_start = 1'b1;
                    burst_kind_nxt  = jmse_pkg::KIND_EXIF;
                    state_nxt       = PH_BURST;
                  end
                end else if (st.total_short || st.rem_last) begin
                  state_nxt = skip_next;
                end else begin
                  state_nxt = PH_APP1;
                end
              end else if (st.at_xmp) begin
                if (st.xmp_hit && !st.cap[1]) begin
                  cmd.burst_start = 1'b1;
                  burst_kind_nxt  = jmse_pkg::KIND_XMP;
                  state_nxt       = PH_BURST;
                end else begin
                  state_nxt = skip_next;
                end
              end else if (st.rem_last) begin
                state_nxt = skip_next;
              end else begin
                state_nxt = PH_APP1;
              end
            end
            PH_EXIF, PH_XMP, PH_IPTC: begin
              cmd.op       = jmse_pkg::DP_COUNT;
              cmd.out_load = 1'b1;
              cmd.out_last = st.rem_last;
              cmd.out_kind = (eff == PH_EXIF) ? jmse_pkg::KIND_EXIF :
                             (eff == PH_XMP)  ? jmse_pkg::KIND_XMP  : jmse_pkg::KIND_IPTC;
              if (st.rem_last) begin
                cmd.cap_set = jmse_pkg::kind_bit(cmd.out_kind);
                seg_next    = ((st.cap | cmd.cap_set) == jmse_pkg::CAP_ALL) ? PH_END_PEND
                                                                            : PH_MARK_START;
                state_nxt   = seg_next;
              end
            end
            PH_ICC: begin
              cmd.op       = jmse_pkg::DP_ICC;
              cmd.out_load = 1'b1;
              cmd.out_kind = jmse_pkg::KIND_ICC;
              cmd.out_last = st.rem_last;
              cmd.out_ok   = st.rem_last && st.icc_ok;
              if (st.rem_last) begin
                cmd.cap_set = st.icc_ok ? jmse_pkg::kind_bit(jmse_pkg::KIND_ICC) : 4'b0000;
                seg_next    = ((st.cap | cmd.cap_set) == jmse_pkg::CAP_ALL) ? PH_END_PEND
                                                                            : PH_MARK_START;
                state_nxt   = seg_next;
              end
            end
            default: ;  // parse ended: drop the byte
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= PH_MARK_START;
      burst_kind_r <= jmse_pkg::KIND_EXIF;
    end else begin
      state_r      <= state_nxt;
      burst_kind_r <= burst_kind_nxt;
    end
  end

endmodule

// ===== rtl/core/jmse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG metadata extractor checker
// Port-level properties of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module jmse_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input jmse_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input jmse_pkg::out_item_t out_item
);

  // End item carries a zero byte and closes its segment
  a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == jmse_pkg::KIND_END) |->
      (out_item.payload_byte == 8'h00) && out_item.last_of_segment)
    else $error("end item malformed");

  // Header-ok flag only on the final ICC byte
  a_icc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.icc_header_ok |->
      (out_item.kind == jmse_pkg::KIND_ICC) && out_item.last_of_segment)
    else $error("icc_header_ok outside last ICC byte");

  // A blocked result blocks input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while result stalled");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind jpeg_metadata_segment_extractor jmse_checker u_jmse_checker (.*);

// ===== test/jmse_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG metadata extractor scoreboard
// Tracks marker parsing byte by byte, queues the payload items the extractor
// should emit, and compares every emitted item against the oldest one queued.
// ----------------------------------------------------------------------------
package jmse_scoreboard_pkg;
  import jmse_pkg::*;

  typedef enum logic [3:0] {
    PS_MARK_START,
    PS_MARK_CODE,
    PS_LEN_HI,
    PS_LEN_LO,
    PS_SKIP,
    PS_APP1,
    PS_EXIF,
    PS_XMP,
    PS_ICC,
    PS_IPTC,
    PS_DONE
  } parse_state_e;

  localparam int REPORT_LIMIT = 10;

  class metadata_scoreboard;
    parse_state_e state;
    int unsigned  remaining;
    logic [7:0]   marker;
    logic [3:0]   captured;
    logic [7:0]   prefix [PREFIX_DEPTH_DEF];
    int unsigned  held;
    int unsigned  icc_pos;
    bit           icc_good;
    out_item_t    expected_payload[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  kind_seen [5];

    function new();
      clear();
      errors  = 0;
      checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void clear();
      state     = PS_MARK_START;
      remaining = 0;
      marker    = 8'h00;
      captured  = 4'h0;
      held      = 0;
      icc_pos   = 0;
      icc_good  = 1'b1;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function int unsigned pending();
      return expected_payload.size();
    endfunction

    function void emit(logic [7:0] b, kind_t k, logic last, logic ok);
      out_item_t r;
      r.payload_byte    = b;
      r.kind            = k;
      r.last_of_segment = last;
      r.icc_header_ok   = ok;
      expected_payload.push_back(r);
    endfunction

    function void end_parse();
      state = PS_DONE;
      emit(8'h00, KIND_END, 1'b1, 1'b0);
    endfunction

    function void segment_done(logic [3:0] mask);
      captured |= mask;
      state = PS_MARK_START;
      if (captured == CAP_ALL) end_parse();
    endfunction

    function void skip_rest();
      state = (remaining == 0) ? PS_MARK_START : PS_SKIP;
    endfunction

    // Flush the held APP1 bytes as one burst of the decided kind.
    function void release_prefix(kind_t k, parse_state_e nxt);
      for (int i = 0; i < held && i < PREFIX_DEPTH_DEF; i++)
        emit(prefix[i], k, remaining == 0 && i + 1 == held, 1'b0);
      if (remaining == 0) segment_done(4'b0001 << k);
      else state = nxt;
    endfunction

    // Advance the parse by one accepted byte; returns 0 when the byte is ignored.
    function bit note_byte(in_item_t it);
      logic [7:0]  b;
      int unsigned total;
      bit          hit;
      bit          active;
      bit          ok;
      kind_t       k;
      b = it.data_byte;
      if (it.new_image) clear();
      active = (state != PS_DONE);
      case (state)
        PS_MARK_START: begin
          if (b == MARK_PREFIX) state = PS_MARK_CODE;
          else end_parse();
        end
        PS_MARK_CODE: begin
          if (b[7:4] == MARK_APPN_HI || b == MARK_COM) begin
            marker    = b;
            remaining = 0;
            state     = PS_LEN_HI;
          end else begin
            state = PS_MARK_START;
          end
        end
        PS_LEN_HI: begin
          remaining = {b, 8'h00};
          state     = PS_LEN_LO;
        end
        PS_LEN_LO: begin
          remaining = remaining | b;
          if (remaining > 2) remaining -= 2;
          if (remaining == 0) begin
            state = PS_MARK_START;
          end else if (marker == MARK_APP1 && captured[1:0] != 2'b11) begin
            held  = 0;
            state = (remaining < LEN_SIG_EXIF) ? PS_SKIP : PS_APP1;
          end else if (marker == MARK_APP2 && !captured[2] && remaining > LEN_ICC_HDR) begin
            icc_pos  = 0;
            icc_good = 1'b1;
            state    = PS_ICC;
          end else if (marker == MARK_IPTC && !captured[3]) begin
            state = PS_IPTC;
          end else begin
            state = PS_SKIP;
          end
          marker = 8'h00;
        end
        PS_SKIP: begin
          if (remaining > 0) remaining--;
          if (remaining == 0) state = PS_MARK_START;
        end
        PS_APP1: begin
          if (held < PREFIX_DEPTH_DEF) prefix[held] = b;
          held++;
          total = remaining;
          if (remaining > 0) remaining--;
          if (held == LEN_SIG_EXIF) begin
            hit = 1'b1;
            for (int i = 0; i < LEN_SIG_EXIF; i++)
              if (prefix[i] != SIG_EXIF[8*(LEN_SIG_EXIF-1-i) +: 8]) hit = 1'b0;
            if (hit) begin
              if (captured[0]) skip_rest();
              else release_prefix(KIND_EXIF, PS_EXIF);
            end else if (total + LEN_SIG_EXIF - 1 < LEN_SIG_XMP) begin
              skip_rest();
            end else if (remaining == 0) begin
              skip_rest();
            end
          end else if (held >= LEN_SIG_XMP) begin
            hit = !captured[1];
            for (int i = 0; i < LEN_SIG_XMP; i++)
              if (prefix[i] != SIG_XMP[8*(LEN_SIG_XMP-1-i) +: 8]) hit = 1'b0;
            if (hit) release_prefix(KIND_XMP, PS_XMP);
            else skip_rest();
          end else if (remaining == 0) begin
            skip_rest();
          end
        end
        PS_EXIF, PS_XMP, PS_IPTC: begin
          k = (state == PS_EXIF) ? KIND_EXIF : (state == PS_XMP) ? KIND_XMP : KIND_IPTC;
          if (remaining > 0) remaining--;
          emit(b, k, remaining == 0, 1'b0);
          if (remaining == 0) segment_done(4'b0001 << k);
        end
        PS_ICC: begin
          if (icc_pos < LEN_ICC_HDR) begin
            if (b != ICC_HDR[8*(LEN_ICC_HDR-1-icc_pos) +: 8]) icc_good = 1'b0;
            icc_pos++;
          end
          if (remaining > 0) remaining--;
          if (remaining == 0) begin
            ok = icc_good && icc_pos >= LEN_ICC_HDR;
            emit(b, KIND_ICC, 1'b1, ok);
            segment_done(ok ? 4'b0100 : 4'b0000);
          end else begin
            emit(b, KIND_ICC, 1'b0, 1'b0);
          end
        end
        default: ;
      endcase
      return active;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (got.kind <= KIND_END) kind_seen[int'(got.kind)]++;
      if (expected_payload.size() == 0) begin
        report($sformatf("result %0d unexpected: byte %02h kind %0d last %b ok %b",
                         checked, got.payload_byte, got.kind, got.last_of_segment,
                         got.icc_header_ok));
        return;
      end
      want = expected_payload.pop_front();
      if (got.payload_byte !== want.payload_byte || got.kind !== want.kind ||
          got.last_of_segment !== want.last_of_segment ||
          got.icc_header_ok !== want.icc_header_ok)
        report($sformatf({"result %0d mismatch: expected byte %02h kind %s last %b ok %b,",
                          " got byte %02h kind %0d last %b ok %b"},
                         checked, want.payload_byte, want.kind.name(), want.last_of_segment,
                         want.icc_header_ok, got.payload_byte, got.kind,
                         got.last_of_segment, got.icc_header_ok));
    endfunction

    function void close_out();
      if (expected_payload.size() != 0)
        report($sformatf("%0d expected results never arrived, oldest byte %02h kind %s",
                         expected_payload.size(), expected_payload[0].payload_byte,
                         expected_payload[0].kind.name()));
    endfunction
  endclass

endpackage

// ===== test/tb_jpeg_metadata_segment_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG metadata segment extractor testbench
// Streams short hand-built marker sequences and then randomized JPEG-like
// files through the extractor under three sender/receiver idle patterns, and
// checks every emitted payload item against a scoreboard that parses the same
// bytes.
// ----------------------------------------------------------------------------
module tb_jpeg_metadata_segment_extractor;
  import jmse_pkg::*;
  import jmse_scoreboard_pkg::*;

  // Bytes sent per idle pattern; whole files are sent, so a pass runs past
  // this by the tail of its last file.
  localparam int ITEMS_PER_PASS = 30;
  // Longest quiet stretch after the last expected item: a full XMP burst and more.
  localparam int DRAIN_CYCLES   = 64;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int RUN_LIMIT_NS   = 2_000_000;

  localparam logic [7:0] MARK_APP0 = 8'hE0;
  localparam logic [7:0] MARK_SOI  = 8'hD8;
  localparam logic [7:0] MARK_EOI  = 8'hD9;

  // Segment shapes the random file builder can lay down.
  typedef enum logic [2:0] {
    SEG_EXIF,
    SEG_XMP,
    SEG_ICC,
    SEG_IPTC,
    SEG_OTHER_APP,
    SEG_ODD_LEN,
    SEG_BARE_MARKER,
    SEG_NOISE
  } seg_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  metadata_scoreboard sb;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned bytes_live;
  int unsigned bytes_sent;
  int unsigned files_sent;

  jpeg_metadata_segment_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random with the current idle rate, updated every rising edge.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Inputs only move at the rising edge, so the values seen at the falling edge
  // are the ones the next rising edge accepts. Check results there.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Present one byte, optionally after a random idle gap, and hold it until
  // the extractor takes it. Returns at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic ni);
    in_item_t it;
    it.data_byte = b;
    it.new_image = ni;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    if (sb.note_byte(it)) bytes_live++;
    bytes_sent++;
    @(posedge clk);
  endtask

  // Marker start, marker code and the big-endian length field as written.
  task automatic send_header(input logic [7:0] code, input logic [15:0] len_field);
    send_byte(MARK_PREFIX, 1'b0);
    send_byte(code, 1'b0);
    send_byte(len_field[15:8], 1'b0);
    send_byte(len_field[7:0], 1'b0);
  endtask

  // Build and send one segment. A segment that is not clean may carry a
  // damaged signature or a too-short ICC payload.
  task automatic send_seg(input seg_e s, input bit clean);
    logic [7:0]  body[$];
    logic [7:0]  code;
    int unsigned sig_len;
    int unsigned extra;
    int unsigned idx;
    int unsigned len_field;
    sig_len = 0;
    code    = MARK_APP1;
    extra   = 0;
    case (s)
      SEG_EXIF: begin
        sig_len = LEN_SIG_EXIF;
        for (int i = 0; i < LEN_SIG_EXIF; i++)
          body.push_back(SIG_EXIF[8*(LEN_SIG_EXIF-1-i) +: 8]);
        extra = $urandom_range(6);
      end
      SEG_XMP: begin
        sig_len = LEN_SIG_XMP;
        for (int i = 0; i < LEN_SIG_XMP; i++)
          body.push_back(SIG_XMP[8*(LEN_SIG_XMP-1-i) +: 8]);
        extra = $urandom_range(4);
      end
      SEG_ICC: begin
        code    = MARK_APP2;
        sig_len = LEN_ICC_HDR;
        for (int i = 0; i < LEN_ICC_HDR; i++)
          body.push_back(ICC_HDR[8*(LEN_ICC_HDR-1-i) +: 8]);
        // No extra byte leaves the payload at the header size: not taken as ICC.
        extra = $urandom_range(4, clean ? 1 : 0);
      end
      SEG_IPTC: begin
        code  = MARK_IPTC;
        extra = $urandom_range(6, 1);
      end
      SEG_OTHER_APP: begin
        code  = ($urandom_range(4) == 0) ? MARK_COM : {MARK_APPN_HI, 4'($urandom)};
        // Long random APP1 bodies reach the XMP decision point and get skipped.
        extra = ($urandom_range(3) == 0) ? $urandom_range(34, 25) : $urandom_range(8, 1);
      end
      SEG_ODD_LEN: begin
        // Length fields 0, 1 and 2 on any APPn, with as many bytes as kept.
        code      = {MARK_APPN_HI, 4'($urandom)};
        len_field = $urandom_range(2);
        send_header(code, 16'(len_field));
        repeat (len_field) send_byte(8'($urandom), 1'b0);
        return;
      end
      SEG_BARE_MARKER: begin
        do code = 8'($urandom); while (code[7:4] == MARK_APPN_HI || code == MARK_COM);
        send_byte(MARK_PREFIX, 1'b0);
        send_byte(code, 1'b0);
        return;
      end
      default: begin
        // Stray byte, sometimes flagged as the start of a new image.
        send_byte(8'($urandom), $urandom_range(7) == 0);
        return;
      end
    endcase
    repeat (extra) body.push_back(8'($urandom));
    if (!clean && sig_len > 0 && $urandom_range(2) == 0) begin
      idx = $urandom_range(sig_len - 1);
      body[idx] = body[idx] ^ 8'(1 << $urandom_range(7));
    end
    send_header(code, 16'(body.size() + 2));
    foreach (body[i]) send_byte(body[i], 1'b0);
  endtask

  // One file: a fresh image, a run of segments, EOI and a terminating byte.
  // A third of the files carry all four kinds cleanly so that capture completes.
  task automatic send_file();
    int unsigned start;
    int unsigned pick;
    bit          full;
    full = ($urandom_range(2) == 0);
    send_byte(MARK_PREFIX, 1'b1);
    send_byte(MARK_SOI, 1'b0);
    if (full) begin
      start = $urandom_range(3);
      for (int j = 0; j < 4; j++) begin
        if ($urandom_range(2) == 0) send_seg(SEG_OTHER_APP, 1'b1);
        send_seg(seg_e'((start + j) % 4), 1'b1);
      end
    end else begin
      repeat ($urandom_range(3, 1)) begin
        pick = $urandom_range(99);
        send_seg(pick < 18 ? SEG_EXIF :
                 pick < 32 ? SEG_XMP :
                 pick < 47 ? SEG_ICC :
                 pick < 60 ? SEG_IPTC :
                 pick < 75 ? SEG_OTHER_APP :
                 pick < 83 ? SEG_BARE_MARKER :
                 pick < 91 ? SEG_ODD_LEN : SEG_NOISE,
                 $urandom_range(2) != 0);
      end
    end
    send_byte(MARK_PREFIX, 1'b0);
    send_byte(MARK_EOI, 1'b0);
    // Any byte other than 0xFF where a marker is due ends the parse.
    send_byte(8'($urandom_range(254)), 1'b0);
    repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
    files_sent++;
  endtask

  task automatic run_pass(input int unsigned src_idle, input int unsigned dst_idle);
    int unsigned floor_mark;
    in_idle_pct  = src_idle;
    out_idle_pct = dst_idle;
    floor_mark   = bytes_sent;
    while (bytes_sent < floor_mark + ITEMS_PER_PASS) send_file();
  endtask

  initial begin
    int unsigned waited;
    sb           = new();
    in_idle_pct  = 13;
    out_idle_pct = 59;
    bytes_live   = 0;
    bytes_sent   = 0;
    files_sent   = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    out_stall <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a further 0xFF taken as a marker code, a zero length, a COM
    // of length 1, an IPTC of length 2 with both byte extremes, an APP1 too
    // short for any signature, then the end byte and one ignored byte.
    send_byte(MARK_PREFIX, 1'b1);
    send_byte(MARK_PREFIX, 1'b0);
    send_header(MARK_APP0, 16'd0);
    send_header(MARK_COM, 16'd1);
    send_byte(8'hAA, 1'b0);
    send_header(MARK_IPTC, 16'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_header(MARK_APP1, 16'd6);
    for (int i = 0; i < LEN_SIG_EXIF - 1; i++)
      send_byte(SIG_EXIF[8*(LEN_SIG_EXIF-1-i) +: 8], 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);

    // Random files: slow receiver, then slow sender, then full rate.
    run_pass(13, 59);
    run_pass(59, 13);
    run_pass(0, 0);
    in_valid <= 1'b0;

    // Drain: wait for every queued item, then allow stray late items to show.
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.close_out();

    $display("Sent %0d bytes (%0d parsed) in %0d files across three idle patterns.",
             bytes_sent, bytes_live, files_sent);
    $display("Checked %0d items: exif %0d, xmp %0d, icc %0d, iptc %0d, end %0d; %0d errors.",
             sb.checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2],
             sb.kind_seen[3], sb.kind_seen[4], sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
